// File: hdl/lps_pkg.sv
// shared constants and status types for the lookahead point search core
// no dependencies; imported by every file but the multiplier, root and divider units
`default_nettype none

package lps_pkg;

	// heading field width, full scale is plus or minus pi
	localparam int HEAD_W = 16;

	// depth of the job queue between front and back
	localparam int JOB_DEPTH = 2;

	// job queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// File: hdl/lps_in_if.sv
// path point channel: valid/ready handshake with point payload
// depends on lps_pkg
`default_nettype none

interface lps_in_if import lps_pkg::*; #(
	parameter int CW = 32
) ();
	logic                     valid;
	logic                     ready;
	logic signed [CW-1:0]     point_x;
	logic signed [CW-1:0]     point_y;
	logic signed [HEAD_W-1:0] point_heading;
	logic [CW-2:0]            radius;
	logic                     last_point;

	modport source (
		output valid, point_x, point_y, point_heading, radius, last_point,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_heading, radius, last_point,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/lps_out_if.sv
// lookahead target channel: valid/ready handshake with target payload
// depends on lps_pkg
`default_nettype none

interface lps_out_if import lps_pkg::*; #(
	parameter int CW = 32
) ();
	logic                     valid;
	logic                     ready;
	logic signed [CW-1:0]     target_x;
	logic signed [CW-1:0]     target_y;
	logic signed [HEAD_W-1:0] target_heading;
	logic                     was_interpolated;
	logic                     fell_back_to_end;

	modport source (
		output valid, target_x, target_y, target_heading, was_interpolated,
		       fell_back_to_end,
		input  ready
	);
	modport sink (
		input  valid, target_x, target_y, target_heading, was_interpolated,
		       fell_back_to_end,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/lps_fifo.sv
// small register queue carrying jobs from the front to the back
// depends on lps_pkg for depth and status type
`default_nettype none

module lps_fifo import lps_pkg::*; #(
	parameter int W = 338
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output q_stat_t           stat
);
	localparam int PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
	localparam int CNW = $clog2(JOB_DEPTH + 1);

	logic [W-1:0]   mem_q [JOB_DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CNW-1:0] cnt_q;

	assign rdata      = mem_q[rd_q];
	assign stat.full  = (cnt_q == CNW'(JOB_DEPTH));
	assign stat.empty = (cnt_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(JOB_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(JOB_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

`default_nettype wire

// File: hdl/lps_front.sv
// front part: squares each point and the radius, compares, tracks the path
// and queues one job per path; depends on lps_pkg and lps_in_if
`default_nettype none

module lps_front import lps_pkg::*; #(
	parameter int CW = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	lps_in_if.sink                         pt,
	input  wire logic                      interp_en,
	input  wire q_stat_t                   stat,
	output logic                           push,
	output logic [10*CW+HEAD_W+1:0]        job
);
	typedef struct packed {
		logic                     interp;
		logic                     fallback;
		logic signed [CW-1:0]     x;
		logic signed [CW-1:0]     y;
		logic signed [CW-1:0]     x1;
		logic signed [CW-1:0]     y1;
		logic signed [HEAD_W-1:0] heading;
		logic [2*CW-1:0]          d2;
		logic [2*CW-1:0]          d1;
		logic [2*CW-1:0]          r2;
	} job_t;

	logic                     adv;
	logic                     v_s1, v_s2;
	logic signed [CW-1:0]     x_s1, y_s1, x_s2, y_s2;
	logic signed [HEAD_W-1:0] h_s1, h_s2;
	logic [CW-2:0]            r_s1;
	logic                     last_s1, last_s2;
	logic signed [2*CW-1:0]   sq_x, sq_y;
	logic [2*CW-1:0]          sq_r;
	logic [2*CW-1:0]          xx_s2, yy_s2, rr_s2;
	logic [2*CW-1:0]          d2;
	logic                     ge;
	logic signed [CW-1:0]     prev_x_q, prev_y_q;
	logic [2*CW-1:0]          prev_d2_q;
	logic                     have_prev_q, found_q;
	job_t                     jb;

	// whole pipe stalls only while a stage-two point meets a full queue
	assign adv      = !(v_s2 && stat.full);
	assign pt.ready = adv;

	// squares of the stage one point
	assign sq_x = x_s1 * x_s1;
	assign sq_y = y_s1 * y_s1;
	assign sq_r = {{(CW+1){1'b0}}, r_s1} * {{(CW+1){1'b0}}, r_s1};

	// distance compare in stage two
	assign d2 = xx_s2 + yy_s2;
	assign ge = (d2 >= rr_s2);

	// job for the back part
	always_comb begin
		jb.interp   = ge && interp_en && have_prev_q;
		jb.fallback = !ge;
		jb.x        = x_s2;
		jb.y        = y_s2;
		jb.x1       = prev_x_q;
		jb.y1       = prev_y_q;
		jb.heading  = h_s2;
		jb.d2       = d2;
		jb.d1       = prev_d2_q;
		jb.r2       = rr_s2;
	end
	assign job  = jb;
	assign push = v_s2 && adv && !found_q && (ge || last_s2);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt.valid;
			v_s2 <= v_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= pt.point_x;
			y_s1    <= pt.point_y;
			h_s1    <= pt.point_heading;
			r_s1    <= pt.radius;
			last_s1 <= pt.last_point;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			h_s2    <= h_s1;
			last_s2 <= last_s1;
			xx_s2   <= sq_x;
			yy_s2   <= sq_y;
			rr_s2   <= sq_r;
		end
	end

	// path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
		end else if (v_s2 && adv) begin
			if (found_q || ge || last_s2) begin
				if (last_s2) begin
					have_prev_q <= 1'b0;
					found_q     <= 1'b0;
				end else begin
					found_q <= 1'b1;
				end
			end else begin
				have_prev_q <= 1'b1;
			end
		end
	end

	// predecessor inside the circle
	always_ff @(posedge clk) begin
		if (v_s2 && adv && !found_q && !ge && !last_s2) begin
			prev_x_q  <= x_s2;
			prev_y_q  <= y_s2;
			prev_d2_q <= d2;
		end
	end
endmodule

`default_nettype wire

// File: hdl/lps_mul.sv
// shift and add multiplier, one multiplier bit per cycle, unsigned operands
// no dependencies
`default_nettype none

module lps_mul #(
	parameter int MW = 66
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [MW-1:0] a,
	input  wire logic [MW-1:0] b,
	output logic               done,
	output logic [2*MW-1:0]    p
);
	localparam int CNW = $clog2(MW);

	logic [MW-1:0]   a_q;
	logic [2*MW-1:0] p_q;
	logic [CNW-1:0]  cnt_q;
	logic            busy_q, done_q;
	logic [MW:0]     sum;

	// partial sum into the upper half
	assign sum  = {1'b0, p_q[2*MW-1:MW]} + (p_q[0] ? {1'b0, a_q} : '0);
	assign done = done_q;
	assign p    = p_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MW{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[MW-1:1]};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

`default_nettype wire

// File: hdl/lps_sqrt.sv
// integer square root, one root bit per cycle, restoring digit recurrence
// no dependencies
`default_nettype none

module lps_sqrt #(
	parameter int RB = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [2*RB-1:0] n,
	output logic                 done,
	output logic [RB-1:0]        root
);
	localparam int CNW = $clog2(RB);

	logic [2*RB-1:0] n_q;
	logic [RB+1:0]   rem_q;
	logic [RB-1:0]   root_q;
	logic [CNW-1:0]  cnt_q;
	logic            busy_q, done_q;
	logic [RB+3:0]   rem_x, trial;
	logic            fit;

	// trial subtract of the next root bit
	assign rem_x = {rem_q, n_q[2*RB-1:2*RB-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fit   = (rem_x >= trial);
	assign done  = done_q;
	assign root  = root_q;

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= {n_q[2*RB-3:0], 2'b00};
			rem_q  <= fit ? (RB+2)'(rem_x - trial) : rem_x[RB+1:0];
			root_q <= {root_q[RB-2:0], fit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(RB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

`default_nettype wire

// File: hdl/lps_div.sv
// signed by positive rounded divider: |num| and the rounding offset are formed
// in steps prep1 and prep2, then one quotient bit per cycle; no dependencies
`default_nettype none

module lps_div #(
	parameter int PW = 133,
	parameter int NN = 99,
	parameter int DD = 67
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [PW-1:0] num,
	input  wire logic [DD-2:0]        den,
	output logic                      done,
	output logic                      neg,
	output logic [NN-1:0]             q
);
	localparam int CNW = $clog2(NN);

	logic signed [PW-1:0] num_q;
	logic [PW-1:0]        mag_q;
	logic [DD-2:0]        den_q;
	logic [DD-1:0]        d_q;
	logic [NN-1:0]        n_q, q_q;
	logic [DD-1:0]        rem_q;
	logic                 neg_q;
	logic [CNW-1:0]       cnt_q;
	logic                 prep1_q, prep2_q, busy_q, done_q;
	logic [DD:0]          rem_x;
	logic                 fit;
	logic [PW:0]          nsum;

	assign rem_x = {rem_q, n_q[NN-1]};
	assign fit   = (rem_x >= {1'b0, d_q});
	assign nsum  = {mag_q, 1'b0} + (PW+1)'(den_q);
	assign done  = done_q;
	assign neg   = neg_q;
	assign q     = q_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
		end
		// magnitude and sign
		if (prep1_q) begin
			mag_q <= num_q[PW-1] ? PW'(-num_q) : PW'(num_q);
			neg_q <= num_q[PW-1];
		end
		// doubled operands for round to nearest
		if (prep2_q) begin
			n_q   <= NN'(nsum);
			d_q   <= {den_q, 1'b0};
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[NN-2:0], 1'b0};
			rem_q <= fit ? DD'(rem_x - {1'b0, d_q}) : rem_x[DD-1:0];
			q_q   <= {q_q[NN-2:0], fit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep1_q <= 1'b0;
			prep2_q <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q  <= 1'b0;
			prep1_q <= start;
			prep2_q <= prep1_q;
			if (prep2_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(NN - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

`default_nettype wire

// File: hdl/lps_back.sv
// back part: takes jobs from the queue, computes the circle and segment
// crossing on shared iterative units, holds the result in an output register
// depends on lps_pkg, lps_out_if, lps_mul, lps_sqrt, lps_div
`default_nettype none

module lps_back import lps_pkg::*; #(
	parameter int CW = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [10*CW+HEAD_W+1:0]   job,
	input  wire q_stat_t                   stat,
	output logic                           pop,
	lps_out_if.source                      tgt
);
	localparam int SA = 2*CW + 3;
	localparam int MW = 2*CW + 2;
	localparam int PW = 2*MW + 1;
	localparam int RB = 2*CW;
	localparam int NB = 4*CW;
	localparam int NN = 3*CW + 3;
	localparam int DD = 2*CW + 3;

	typedef struct packed {
		logic                     interp;
		logic                     fallback;
		logic signed [CW-1:0]     x;
		logic signed [CW-1:0]     y;
		logic signed [CW-1:0]     x1;
		logic signed [CW-1:0]     y1;
		logic signed [HEAD_W-1:0] heading;
		logic [2*CW-1:0]          d2;
		logic [2*CW-1:0]          d1;
		logic [2*CW-1:0]          r2;
	} job_t;

	typedef enum logic [16:0] {
		ST_IDLE = 17'h00001,
		ST_XY   = 17'h00002,
		ST_YX   = 17'h00004,
		ST_DX2  = 17'h00008,
		ST_DY2  = 17'h00010,
		ST_RD   = 17'h00020,
		ST_DD   = 17'h00040,
		ST_SQ   = 17'h00080,
		ST_XS   = 17'h00100,
		ST_DDY  = 17'h00200,
		ST_GOX  = 17'h00400,
		ST_DVX  = 17'h00800,
		ST_YS   = 17'h01000,
		ST_DDX  = 17'h02000,
		ST_GOY  = 17'h04000,
		ST_DVY  = 17'h08000,
		ST_OUT  = 17'h10000
	} state_t;

	state_t                   state_q;
	logic                     iss_q;
	job_t                     jb;
	logic                     free;
	logic                     load_pass, load_res;

	logic signed [CW-1:0]     x_q, y_q, x1_q, y1_q;
	logic signed [HEAD_W-1:0] h_q;
	logic [2*CW-1:0]          r2_q;
	logic                     gneg_q;
	logic signed [CW:0]       dx_q, dy_q;
	logic signed [PW-1:0]     acc_q, num_q;
	logic signed [SA-1:0]     dd_q;
	logic [DD-2:0]            dr2_q;
	logic [NB-1:0]            rad_q;
	logic [RB-1:0]            s_q;
	logic signed [CW-1:0]     tx_q, ty_q;
	logic                     ti_q;

	logic                     ov_q, oi_q, of_q;
	logic signed [CW-1:0]     ox_q, oy_q;
	logic signed [HEAD_W-1:0] oh_q;

	logic                     is_mul;
	logic signed [SA-1:0]     opa, opb, nega, negb;
	logic                     mul_start, mul_done, mneg_q;
	logic [2*MW-1:0]          mul_p;
	logic signed [PW-1:0]     prod, sum_ap, dif_ap;
	logic                     sq_start, sq_done;
	logic [RB-1:0]            sq_root;
	logic                     div_start, div_done, div_neg;
	logic [NN-1:0]            div_q;
	logic signed [CW-1:0]     sat_val;

	// saturate a rounded quotient magnitude to the coordinate range
	function automatic logic signed [CW-1:0] sat(input logic [NN-1:0] m, input logic n);
		logic [NN-1:0] lim;
		logic [NN-1:0] mn;
		lim = NN'(1) << (CW - 1);
		mn  = NN'(0) - m;
		if (n) begin
			sat = (m > lim) ? CW'(lim) : mn[CW-1:0];
		end else begin
			sat = (m >= lim) ? CW'(lim - 1'b1) : m[CW-1:0];
		end
	endfunction

	assign jb      = job_t'(job);
	assign free    = !ov_q || tgt.ready;
	assign sat_val = sat(div_q, div_neg);

	// queue pop: crossings start at once, plain points need the output free
	assign load_pass = (state_q == ST_IDLE) && !stat.empty && !jb.interp && free;
	assign pop       = (state_q == ST_IDLE) && !stat.empty && (jb.interp || free);
	assign load_res  = (state_q == ST_OUT) && free;

	// multiplier operand selection
	always_comb begin
		is_mul = 1'b1;
		case (state_q)
			ST_XY:   begin opa = SA'(x1_q); opb = SA'(y_q);   end
			ST_YX:   begin opa = SA'(x_q);  opb = SA'(y1_q);  end
			ST_DX2:  begin opa = SA'(dx_q); opb = SA'(dx_q);  end
			ST_DY2:  begin opa = SA'(dy_q); opb = SA'(dy_q);  end
			ST_RD:   begin opa = SA'(r2_q); opb = SA'(dr2_q); end
			ST_DD:   begin opa = dd_q;      opb = dd_q;       end
			ST_XS:   begin opa = SA'(dx_q); opb = SA'(s_q);   end
			ST_DDY:  begin opa = dd_q;      opb = SA'(dy_q);  end
			ST_YS:   begin opa = SA'(dy_q); opb = SA'(s_q);   end
			ST_DDX:  begin opa = dd_q;      opb = SA'(dx_q);  end
			default: begin opa = '0; opb = '0; is_mul = 1'b0; end
		endcase
	end

	assign nega      = -opa;
	assign negb      = -opb;
	assign mul_start = is_mul && !iss_q;
	assign sq_start  = (state_q == ST_SQ) && !iss_q;
	assign div_start = (state_q == ST_GOX) || (state_q == ST_GOY);

	// signed product and the two combinations with the accumulator
	assign prod   = mneg_q ? -PW'({1'b0, mul_p}) : PW'({1'b0, mul_p});
	assign sum_ap = acc_q + prod;
	assign dif_ap = acc_q - prod;

	lps_mul #(.MW(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (opa[SA-1] ? MW'(nega) : MW'(opa)),
		.b      (opb[SA-1] ? MW'(negb) : MW'(opb)),
		.done   (mul_done),
		.p      (mul_p)
	);

	lps_sqrt #(.RB(RB)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n      (rad_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	lps_div #(.PW(PW), .NN(NN), .DD(DD)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (dr2_q),
		.done   (div_done),
		.neg    (div_neg),
		.q      (div_q)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q   <= 1'b0;
		end else begin
			if (mul_start || sq_start) begin
				iss_q <= 1'b1;
			end else if (mul_done || sq_done) begin
				iss_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (pop && jb.interp) state_q <= ST_XY;
				ST_XY:   if (mul_done) state_q <= ST_YX;
				ST_YX:   if (mul_done) state_q <= ST_DX2;
				ST_DX2:  if (mul_done) state_q <= ST_DY2;
				ST_DY2:  if (mul_done) state_q <= (sum_ap == '0) ? ST_OUT : ST_RD;
				ST_RD:   if (mul_done) state_q <= ST_DD;
				ST_DD:   if (mul_done) state_q <= ST_SQ;
				ST_SQ:   if (sq_done) state_q <= ST_XS;
				ST_XS:   if (mul_done) state_q <= ST_DDY;
				ST_DDY:  if (mul_done) state_q <= ST_GOX;
				ST_GOX:  state_q <= ST_DVX;
				ST_DVX:  if (div_done) state_q <= ST_YS;
				ST_YS:   if (mul_done) state_q <= ST_DDX;
				ST_DDX:  if (mul_done) state_q <= ST_GOY;
				ST_GOY:  state_q <= ST_DVY;
				ST_DVY:  if (div_done) state_q <= ST_OUT;
				ST_OUT:  if (free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_start) begin
			mneg_q <= opa[SA-1] ^ opb[SA-1];
		end
		if (pop && jb.interp) begin
			x_q    <= jb.x;
			y_q    <= jb.y;
			x1_q   <= jb.x1;
			y1_q   <= jb.y1;
			h_q    <= jb.heading;
			r2_q   <= jb.r2;
			gneg_q <= (jb.d2 < jb.d1);
			dx_q   <= (CW+1)'(jb.x) - (CW+1)'(jb.x1);
			dy_q   <= (CW+1)'(jb.y) - (CW+1)'(jb.y1);
		end
		if (mul_done) begin
			case (state_q)
				ST_XY, ST_DX2, ST_RD: acc_q <= prod;
				ST_YX:  dd_q <= SA'(dif_ap);
				ST_DY2: begin
					dr2_q <= (DD-1)'(sum_ap);
					tx_q  <= x_q;
					ty_q  <= y_q;
					ti_q  <= 1'b0;
				end
				ST_DD:  rad_q <= dif_ap[PW-1] ? '0 : NB'(dif_ap);
				ST_XS, ST_YS: acc_q <= gneg_q ? -prod : prod;
				ST_DDY: num_q <= sum_ap;
				ST_DDX: num_q <= dif_ap;
				default: ;
			endcase
		end
		if (sq_done) begin
			s_q <= sq_root;
		end
		if (div_done && state_q == ST_DVX) begin
			tx_q <= sat_val;
		end
		if (div_done && state_q == ST_DVY) begin
			ty_q <= sat_val;
			ti_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_pass || load_res) begin
			ov_q <= 1'b1;
		end else if (tgt.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pass) begin
			ox_q <= jb.x;
			oy_q <= jb.y;
			oh_q <= jb.heading;
			oi_q <= 1'b0;
			of_q <= jb.fallback;
		end else if (load_res) begin
			ox_q <= tx_q;
			oy_q <= ty_q;
			oh_q <= h_q;
			oi_q <= ti_q;
			of_q <= 1'b0;
		end
	end

	assign tgt.valid            = ov_q;
	assign tgt.target_x         = ox_q;
	assign tgt.target_y         = oy_q;
	assign tgt.target_heading   = oh_q;
	assign tgt.was_interpolated = oi_q;
	assign tgt.fell_back_to_end = of_q;
endmodule

`default_nettype wire

// File: hdl/lookahead_point_search_core.sv
// lookahead point search: front compare pipeline, job queue, crossing unit
// path: a point that needs no crossing passes the front stages, the job queue
//   and the output register; a crossing also takes the sequencer through ten
//   multiplies, a root and two divides
// throughput: one point per cycle while the two-entry job queue has room
// reset: arst_n clears the path state, queue and sequencer; interpolation is on
`default_nettype none

module lookahead_point_search_core import lps_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_write,
	input  wire logic cfg_data,
	lps_in_if.sink    pt,
	lps_out_if.source tgt
);
	localparam int JW = 10*COORD_WIDTH + HEAD_W + 2;

	logic          interp_en_q;
	logic          push, pop;
	logic [JW-1:0] job_in, job_out;
	q_stat_t       qs;

	// interpolation enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_en_q <= 1'b1;
		end else if (cfg_write) begin
			interp_en_q <= cfg_data;
		end
	end

	lps_front #(.CW(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt        (pt),
		.interp_en (interp_en_q),
		.stat      (qs),
		.push      (push),
		.job       (job_in)
	);

	lps_fifo #(.W(JW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.stat   (qs)
	);

	lps_back #(.CW(COORD_WIDTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job_out),
		.stat   (qs),
		.pop    (pop),
		.tgt    (tgt)
	);

	// the front never queues into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qs.full) else $error("job queue overflow");

	// the back never takes from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qs.empty) else $error("job queue underflow");

	// a stalled point request means the queue was full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pt.ready |-> qs.full) else $error("front stalled without full queue");
endmodule

`default_nettype wire

// File: tb/lps_tb_pkg.sv
// shared types for the lookahead point search testbench
// depends on lps_pkg for the heading width
`timescale 1ns / 100ps

package lps_tb_pkg;
	import lps_pkg::*;

	// one lookahead target as seen on the output channel
	typedef struct {
		logic signed [31:0]       x;
		logic signed [31:0]       y;
		logic signed [HEAD_W-1:0] heading;
		bit                       interp;
		bit                       fallback;
	} target_t;

	// one row of the directed stimulus table
	typedef struct {
		logic signed [31:0]       x;
		logic signed [31:0]       y;
		logic signed [HEAD_W-1:0] heading;
		logic [30:0]              radius;
		bit                       last;
		bit                       typed;
		target_t                  want;
	} point_row_t;

endpackage

// File: tb/testbench.sv
// self-checking testbench for lookahead_point_search_core
// depends on lps_pkg, lps_in_if, lps_out_if, lps_tb_pkg; predicts targets with exact wide maths
`timescale 1ns / 100ps

module testbench;
	import lps_pkg::*;
	import lps_tb_pkg::*;

	typedef logic signed [255:0] wide_t;

	localparam int CW          = 32;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int DRAIN_WAIT  = 1200;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic cfg_data;

	lps_in_if  #(.CW(CW)) pt_if ();
	lps_out_if #(.CW(CW)) tgt_if ();

	lookahead_point_search_core #(.COORD_WIDTH(CW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.pt       (pt_if),
		.tgt      (tgt_if)
	);

	// predictor state
	logic signed [31:0] held_x;
	logic signed [31:0] held_y;
	bit                 held_valid;
	bit                 path_done;
	bit                 interp_on;

	target_t    target_q[$];
	point_row_t rows[$];
	int         mismatches;
	int         cycles;
	bit         quiet;
	bit         hold_req;

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic wide_t root_floor(wide_t n);
		wide_t r, c;
		r = '0;
		for (int i = 70; i >= 0; i--) begin
			c = r | (wide_t'(1) << i);
			if (c * c <= n)
				r = c;
		end
		return r;
	endfunction

	// signed over positive, nearest with ties away from zero, saturated to coordinate range
	function automatic logic signed [31:0] round_sat(wide_t num, wide_t den);
		wide_t m, q;
		m = (num < 0) ? -num : num;
		q = (m + m + den) / (den + den);
		if (num < 0)
			q = -q;
		if (q > wide_t'(32'sh7fffffff))
			return 32'sh7fffffff;
		if (q < -wide_t'(64'sh80000000))
			return 32'sh80000000;
		return q[31:0];
	endfunction

	// advance the path state by one point, return 1 when a target is due
	function automatic bit predict_target(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [HEAD_W-1:0] ph, logic [30:0] pr, bit pl, output target_t t);
		wide_t x, y, r, x1, y1, d2, r2, dx, dy, dr2, dd, d1, rad, s, tx, ty;
		x = px;
		y = py;
		r = {225'd0, pr};
		t.x = px;
		t.y = py;
		t.heading = ph;
		t.interp = 1'b0;
		t.fallback = 1'b0;
		if (path_done) begin
			if (pl) begin
				held_x = '0; held_y = '0; held_valid = 0; path_done = 0;
			end
			return 0;
		end
		d2 = x * x + y * y;
		r2 = r * r;
		if (d2 >= r2) begin
			if (interp_on && held_valid) begin
				x1 = held_x;
				y1 = held_y;
				dx = x - x1;
				dy = y - y1;
				dr2 = dx * dx + dy * dy;
				if (dr2 != 0) begin
					dd = x1 * y - x * y1;
					d1 = x1 * x1 + y1 * y1;
					rad = r2 * dr2 - dd * dd;
					// a segment that misses the circle clamps the root term to zero
					if (rad < 0)
						rad = '0;
					s = root_floor(rad);
					tx = dx * s;
					ty = dy * s;
					if (d2 < d1) begin
						tx = -tx;
						ty = -ty;
					end
					t.x = round_sat(dd * dy + tx, dr2);
					t.y = round_sat(-(dd * dx) + ty, dr2);
					t.interp = 1'b1;
				end
			end
			if (pl) begin
				held_x = '0; held_y = '0; held_valid = 0; path_done = 0;
			end else
				path_done = 1;
			return 1;
		end
		if (pl) begin
			t.fallback = 1'b1;
			held_x = '0; held_y = '0; held_valid = 0; path_done = 0;
			return 1;
		end
		held_x = px;
		held_y = py;
		held_valid = 1;
		return 0;
	endfunction

	// offer one request, predict on acceptance
	task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [HEAD_W-1:0] ph, logic [30:0] pr, bit pl,
			bit typed, target_t want);
		target_t t;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			pt_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pt_if.valid         <= 1'b1;
		pt_if.point_x       <= px;
		pt_if.point_y       <= py;
		pt_if.point_heading <= ph;
		pt_if.radius        <= pr;
		pt_if.last_point    <= pl;
		do @(posedge clk); while (!pt_if.ready);
		if (predict_target(px, py, ph, pr, pl, t))
			target_q = {target_q, (typed ? want : t)};
	endtask

	task automatic drain_targets();
		pt_if.valid <= 1'b0;
		while (target_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_interp(bit v);
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		interp_on = v;
	endtask

	function automatic int spread(int a);
		return int'($urandom_range(0, 2 * a)) - a;
	endfunction

	// random paths: points inside the circle, one crossing, a tail, last flag; or a path ending inside, or a noise item
	task automatic random_paths(int n_items);
		int sent, n_in, n_tail, a;
		logic [30:0] r;
		target_t none;
		none = '{default: '0};
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise across every field bit
				send_point($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1), 0, none);
				sent++;
			end else begin
				r = ($urandom_range(0, 19) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 24));
				a = (r > 31'(1 << 28)) ? (1 << 28) : int'(r);
				n_in = $urandom_range(0, 4);
				n_tail = $urandom_range(0, 2);
				for (int i = 0; i < n_in; i++) begin
					send_point(spread(a / 2), spread(a / 2), $urandom, r, 0, 0, none);
					sent++;
				end
				if ($urandom_range(0, 6) == 0) begin
					// nothing reaches the circle
					send_point(spread(a / 2), spread(a / 2), $urandom, r, 1, 0, none);
					sent++;
				end else begin
					send_point(spread(2 * (a / 2) + 1) * 2, spread(a) * 2, $urandom, r,
						n_tail == 0, 0, none);
					sent++;
					for (int i = 0; i < n_tail; i++) begin
						send_point(spread(a), spread(a), $urandom, r, i == n_tail - 1, 0, none);
						sent++;
					end
				end
			end
		end
	endtask

	function automatic void add_row(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [HEAD_W-1:0] ph, logic [30:0] pr, bit pl, bit typed,
			bit wi, bit fb);
		point_row_t row;
		row.x = px; row.y = py; row.heading = ph; row.radius = pr; row.last = pl;
		row.typed = typed;
		row.want = '{x: px, y: py, heading: ph, interp: wi, fallback: fb};
		rows = {rows, row};
	endfunction

	// result monitor and scoreboard
	always @(posedge clk) begin
		target_t e;
		if (arst_n && tgt_if.valid && tgt_if.ready) begin
			if (target_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected target x=%0d y=%0d", tgt_if.target_x, tgt_if.target_y);
			end else begin
				e = target_q.pop_front();
				if (tgt_if.target_x !== e.x || tgt_if.target_y !== e.y ||
						tgt_if.target_heading !== e.heading ||
						tgt_if.was_interpolated !== e.interp ||
						tgt_if.fell_back_to_end !== e.fallback) begin
					mismatches++;
					if (mismatches <= 10)
						$display("target got %0d %0d %0d %b %b, want %0d %0d %0d %b %b",
							tgt_if.target_x, tgt_if.target_y, tgt_if.target_heading,
							tgt_if.was_interpolated, tgt_if.fell_back_to_end,
							e.x, e.y, e.heading, e.interp, e.fallback);
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		tgt_if.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				tgt_if.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				tgt_if.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			tgt_if.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// main sequence
	initial begin
		cycles = 0;
		mismatches = 0;
		quiet = 0;
		hold_req = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = 1'b0;
		pt_if.valid = 1'b0;
		pt_if.point_x = '0;
		pt_if.point_y = '0;
		pt_if.point_heading = '0;
		pt_if.radius = '0;
		pt_if.last_point = 1'b0;
		held_x = '0; held_y = '0; held_valid = 0; path_done = 0;
		interp_on = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		// zero radius at the origin takes the point itself
		add_row(0, 0, 16'sh7fff, 0, 1, 1, 0, 0);
		// full-scale crossing from a point just off the origin
		add_row(1, 0, -16'sh8000, 31'h7fffffff, 0, 0, 0, 0);
		add_row(32'sh7fffffff, 32'sh80000000, 16'sh1234, 31'h7fffffff, 0, 0, 0, 0);
		// point after the result is ignored and ends the path
		add_row(7, 7, 3, 5, 1, 0, 0, 0);
		// nothing reaches the circle
		add_row(1, 1, -5, 10, 1, 1, 0, 1);
		// zero-length segment emits the point itself
		add_row(5, 0, 11, 10, 0, 0, 0, 0);
		add_row(5, 0, 12, 5, 1, 1, 0, 0);
		// radius change with a segment missing the circle: root term clamps
		add_row(100, 0, 20, 200, 0, 0, 0, 0);
		add_row(0, 100, 21, 10, 1, 0, 0, 0);
		// crossing at the negative extreme
		add_row(0, 0, 30, 31'h7fffffff, 0, 0, 0, 0);
		add_row(32'sh80000000, 0, 31, 31'h7fffffff, 1, 0, 0, 0);
		add_row(0, 32'sh80000000, 32, 31'h7fffffff, 0, 0, 0, 0);
		add_row(-3, 4, 33, 5, 1, 0, 0, 0);
		// ordinary crossing
		add_row(32'sh00010000, 32'sh00008000, 40, 32'sh00030000, 0, 0, 0, 0);
		add_row(32'sh00040000, -32'sh00020000, 41, 32'sh00030000, 1, 0, 0, 0);
		foreach (rows[i])
			send_point(rows[i].x, rows[i].y, rows[i].heading, rows[i].radius, rows[i].last,
				rows[i].typed, rows[i].want);

		// interpolation on, receiver holds off while requests pile up
		hold_req = 1;
		random_paths(300);
		drain_targets();

		// interpolation off
		write_interp(0);
		random_paths(300);
		drain_targets();

		// interpolation back on, sender pauses at random, then no idling at the end
		write_interp(1);
		random_paths(150);
		drain_targets();
		quiet = 1;
		random_paths(150);
		drain_targets();

		if (mismatches == 0 && target_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
